// ----- hdl/tlbfl_pkg.sv -----
// Package for the fully associative translation buffer.
// Holds operation codes, register indexes, default sizes and the
// controller/datapath command and status types. No dependencies.
package tlbfl_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_PAGE_BITS  = 20;
  localparam int DEF_FRAME_BITS = 20;

  // Operation field.
  localparam int OP_W = 2;
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_LOOKUP = 2'd0;
  localparam op_t OP_INSERT = 2'd1;
  localparam op_t OP_FLUSH  = 2'd2;

  // Configuration port.
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY         = 1'd1;
  localparam logic [CFG_W-1:0]     RESET_ENTRIES_IN_USE = 5'd16;

  // Replacement policy codes.
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // Which slot an insert writes.
  typedef logic [1:0] wr_kind_t;
  localparam wr_kind_t WR_HIT    = 2'd0;
  localparam wr_kind_t WR_APPEND = 2'd1;
  localparam wr_kind_t WR_FIFO   = 2'd2;
  localparam wr_kind_t WR_LRU    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_item;
    logic     compare;
    logic     read_frame;
    logic     touch;
    logic     write;
    wr_kind_t wr_kind;
    logic     flush;
    logic     scan_start;
    logic     scan_step;
    logic     load_result;
  } tlbfl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic hit_any;
    logic has_room;
    logic policy_lru;
    logic scan_done;
    logic out_free;
  } tlbfl_status_t;

endpackage

// ----- hdl/tlbfl_in_if.sv -----
// Input channel of the translation buffer: op, page and frame.
// Depends on tlbfl_pkg for the operation width.
interface tlbfl_in_if #(
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 20
);
  import tlbfl_pkg::*;

  logic                  valid;
  logic                  ready;
  op_t                   op;
  logic [PAGE_BITS-1:0]  page;
  logic [FRAME_BITS-1:0] frame;

  modport source (output valid, op, page, frame, input ready);
  modport sink   (input valid, op, page, frame, output ready);
endinterface

// ----- hdl/tlbfl_out_if.sv -----
// Result channel of the translation buffer: hit flag and frame.
// No dependencies.
interface tlbfl_out_if #(
  parameter int FRAME_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [FRAME_BITS-1:0] frame_out;

  modport source (output valid, hit, frame_out, input ready);
  modport sink   (input valid, hit, frame_out, output ready);
endinterface

// ----- hdl/tlb_fifo_lru_unit.sv -----
// Top level of the fully associative translation buffer with FIFO or LRU
// replacement. Depends on tlbfl_pkg, tlbfl_in_if, tlbfl_out_if,
// tlbfl_ctrl and tlbfl_datapath.
//
//   Channel  Direction  Word
//   in_if    sink       op, page, frame
//   out_if   source     hit, frame_out
//   cfg_*    input      write enable, register index, data
//
// Every word passes from acceptance to the next acceptance through latch,
// tag compare, decide and result. An LRU eviction adds a stamp scan of
// filled entries, one stamp memory read per cycle. Reset is synchronous
// and empties the table.
// The result sits in an output register, so a new word is taken while the
// previous result still waits; the block stalls only when that register
// is still full at the end of the next item.
module tlb_fifo_lru_unit #(
  parameter int ENTRIES    = tlbfl_pkg::DEF_ENTRIES,
  parameter int PAGE_BITS  = tlbfl_pkg::DEF_PAGE_BITS,
  parameter int FRAME_BITS = tlbfl_pkg::DEF_FRAME_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tlbfl_in_if.sink                        in_if,
  tlbfl_out_if.source                     out_if,
  input  logic                            cfg_we,
  input  logic [tlbfl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tlbfl_pkg::CFG_W-1:0]     cfg_wdata
);
  import tlbfl_pkg::*;

  tlbfl_cmd_t    cmd;
  tlbfl_status_t status;

  // Sequencer.
  tlbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Table, counters and output register.
  tlbfl_datapath #(
    .ENTRIES    (ENTRIES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .item_op    (in_if.op),
    .item_page  (in_if.page),
    .item_frame (in_if.frame),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .res_valid  (out_if.valid),
    .res_ready  (out_if.ready),
    .res_hit    (out_if.hit),
    .res_frame  (out_if.frame_out)
  );

endmodule

// ----- hdl/tlbfl_datapath.sv -----
// Datapath of the translation buffer: tag row, frame and stamp memories,
// ring pointers, use counter, LRU scan and the output register.
// Depends on tlbfl_pkg.
module tlbfl_datapath #(
  parameter int ENTRIES    = 16,
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tlbfl_pkg::tlbfl_cmd_t          cmd,
  output tlbfl_pkg::tlbfl_status_t       status,
  input  tlbfl_pkg::op_t                 item_op,
  input  logic [PAGE_BITS-1:0]           item_page,
  input  logic [FRAME_BITS-1:0]          item_frame,
  input  logic                           cfg_we,
  input  logic [tlbfl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tlbfl_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic                           res_hit,
  output logic [FRAME_BITS-1:0]          res_frame
);
  import tlbfl_pkg::*;

  localparam int SLOT_W  = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int CAP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int STAMP_W = 32;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Slot at a given position of the insertion ring.
  function automatic slot_t ring_slot(input slot_t base, input cnt_t pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(pos);
    if (sum >= SUM_W'(ENTRIES)) begin
      sum = sum - SUM_W'(ENTRIES);
    end
    return sum[SLOT_W-1:0];
  endfunction

  // Latched item.
  op_t                   op_r;
  logic [PAGE_BITS-1:0]  page_r;
  logic [FRAME_BITS-1:0] frame_in_r;

  // Table storage.
  logic [PAGE_BITS-1:0]  tag_r      [ENTRIES];
  logic [FRAME_BITS-1:0] frame_mem  [ENTRIES];
  logic [STAMP_W-1:0]    stamp_mem  [ENTRIES];
  logic [FRAME_BITS-1:0] frame_q;
  logic [STAMP_W-1:0]    stamp_q;

  // Ring and counter state.
  cnt_t               filled_r;
  slot_t              oldest_r;
  logic [STAMP_W-1:0] counter_r;

  // Configuration.
  logic [CFG_W-1:0] eiu_r;
  logic             policy_r;

  // Match results.
  logic [ENTRIES-1:0] filled_mask;
  logic [ENTRIES-1:0] hit_vec_r;
  slot_t              hit_slot;
  logic               hit_any;

  // LRU scan.
  cnt_t               scan_rd_pos_r;
  cnt_t               proc_cnt_r;
  logic               scan_first_r;
  slot_t              best_slot_r;
  logic [STAMP_W-1:0] best_stamp_r;
  slot_t              rd_slot_q;
  logic               rd_vld_q;
  slot_t              scan_addr;

  // Output register.
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [FRAME_BITS-1:0] out_frame_r;

  // Write addressing.
  slot_t              append_slot;
  slot_t              wr_slot;
  slot_t              stamp_wr_slot;
  logic               stamp_we;
  logic [CAP_W-1:0]   capacity;

  // Slots inside the ring window count as filled.
  always_comb begin
    for (int s = 0; s < ENTRIES; s++) begin
      logic [SUM_W-1:0] span;
      if (SLOT_W'(s) >= oldest_r) begin
        span = SUM_W'(s) - SUM_W'(oldest_r);
      end else begin
        span = SUM_W'(s) + SUM_W'(ENTRIES) - SUM_W'(oldest_r);
      end
      filled_mask[s] = span < SUM_W'(filled_r);
    end
  end

  // Encode the matching slot; at most one filled entry holds a page.
  always_comb begin
    hit_slot = '0;
    for (int s = 0; s < ENTRIES; s++) begin
      if (hit_vec_r[s]) begin
        hit_slot = hit_slot | SLOT_W'(s);
      end
    end
  end
  assign hit_any = |hit_vec_r;

  // Capacity is the register clamped to between one and the table size.
  always_comb begin
    if (eiu_r == '0) begin
      capacity = CAP_W'(1);
    end else if (CAP_W'(eiu_r) > CAP_W'(ENTRIES)) begin
      capacity = CAP_W'(ENTRIES);
    end else begin
      capacity = CAP_W'(eiu_r);
    end
  end

  assign append_slot = ring_slot(oldest_r, filled_r);
  assign scan_addr   = ring_slot(oldest_r, scan_rd_pos_r);

  always_comb begin
    unique case (cmd.wr_kind)
      WR_HIT:    wr_slot = hit_slot;
      WR_APPEND: wr_slot = append_slot;
      WR_FIFO:   wr_slot = append_slot;
      WR_LRU:    wr_slot = best_slot_r;
      default:   wr_slot = append_slot;
    endcase
  end

  assign stamp_we      = cmd.write || cmd.touch;
  assign stamp_wr_slot = cmd.write ? wr_slot : hit_slot;

  // Status toward the controller.
  assign status.op         = op_r;
  assign status.hit_any    = hit_any;
  assign status.has_room   = CAP_W'(filled_r) < capacity;
  assign status.policy_lru = policy_r == POLICY_LRU;
  assign status.scan_done  = proc_cnt_r == filled_r;
  assign status.out_free   = !out_valid_r || res_ready;

  // Item latch and tag compare.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r       <= item_op;
      page_r     <= item_page;
      frame_in_r <= item_frame;
    end
    if (cmd.compare) begin
      for (int s = 0; s < ENTRIES; s++) begin
        hit_vec_r[s] <= filled_mask[s] && (tag_r[s] == page_r);
      end
    end
  end

  // Tag row: written at one slot, compared everywhere.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      tag_r[wr_slot] <= page_r;
    end
  end

  // Frame memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      frame_mem[wr_slot] <= frame_in_r;
    end
    if (cmd.read_frame) begin
      frame_q <= frame_mem[hit_slot];
    end
  end

  // Stamp memory with registered read for the scan.
  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_wr_slot] <= counter_r;
    end
    stamp_q <= stamp_mem[scan_addr];
  end

  // Ring pointers, use counter and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r  <= '0;
      oldest_r  <= '0;
      counter_r <= '0;
      eiu_r     <= RESET_ENTRIES_IN_USE;
      policy_r  <= POLICY_FIFO;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_ENTRIES_IN_USE) begin
          eiu_r <= cfg_wdata;
        end else if (cfg_idx == REG_POLICY) begin
          policy_r <= cfg_wdata[0];
        end
      end
      if (cmd.flush) begin
        filled_r  <= '0;
        oldest_r  <= '0;
        counter_r <= '0;
      end else begin
        if (stamp_we) begin
          counter_r <= counter_r + STAMP_W'(1);
        end
        if (cmd.write && cmd.wr_kind == WR_APPEND) begin
          filled_r <= filled_r + CNT_W'(1);
        end
        if (cmd.write && cmd.wr_kind == WR_FIFO) begin
          oldest_r <= ring_slot(oldest_r, CNT_W'(1));
        end
      end
    end
  end

  // LRU scan: one stamp read per cycle in ring order, latest tie wins.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_q      <= 1'b0;
      scan_rd_pos_r <= '0;
      proc_cnt_r    <= '0;
      scan_first_r  <= 1'b1;
    end else if (cmd.scan_start) begin
      rd_vld_q      <= 1'b0;
      scan_rd_pos_r <= '0;
      proc_cnt_r    <= '0;
      scan_first_r  <= 1'b1;
    end else if (cmd.scan_step) begin
      if (scan_rd_pos_r < filled_r) begin
        rd_vld_q      <= 1'b1;
        rd_slot_q     <= scan_addr;
        scan_rd_pos_r <= scan_rd_pos_r + CNT_W'(1);
      end else begin
        rd_vld_q <= 1'b0;
      end
      if (rd_vld_q) begin
        proc_cnt_r   <= proc_cnt_r + CNT_W'(1);
        scan_first_r <= 1'b0;
        if (scan_first_r || !(best_stamp_r < stamp_q)) begin
          best_slot_r  <= rd_slot_q;
          best_stamp_r <= stamp_q;
        end
      end
    end
  end

  // Output register, freed as the word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_hit_r   <= (op_r == OP_LOOKUP) && hit_any;
      out_frame_r <= ((op_r == OP_LOOKUP) && hit_any) ? frame_q : '0;
    end
  end

  assign res_valid = out_valid_r;
  assign res_hit   = out_hit_r;
  assign res_frame = out_frame_r;

endmodule

// ----- hdl/tlbfl_ctrl.sv -----
// Controller of the translation buffer: sequences compare, decide,
// LRU scan and result load. Depends on tlbfl_pkg.
module tlbfl_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  tlbfl_pkg::tlbfl_status_t status,
  output tlbfl_pkg::tlbfl_cmd_t    cmd
);
  import tlbfl_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.compare = 1'b1;
        state_nxt   = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_RESULT;
        if (status.op == OP_LOOKUP) begin
          cmd.read_frame = 1'b1;
          cmd.touch      = status.hit_any;
        end else if (status.op == OP_INSERT) begin
          priority if (status.hit_any) begin
            cmd.write   = 1'b1;
            cmd.wr_kind = WR_HIT;
          end else if (status.has_room) begin
            cmd.write   = 1'b1;
            cmd.wr_kind = WR_APPEND;
          end else if (!status.policy_lru) begin
            cmd.write   = 1'b1;
            cmd.wr_kind = WR_FIFO;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end else if (status.op == OP_FLUSH) begin
          cmd.flush = 1'b1;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          cmd.write   = 1'b1;
          cmd.wr_kind = WR_LRU;
          state_nxt   = S_RESULT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- tb/sv/tb_tlb_fifo_lru_unit.sv -----
// Self-checking testbench for tlb_fifo_lru_unit: directed and random lookup, insert and flush
// words under FIFO and LRU replacement, with random idling and output back-pressure.
// Depends on tlbfl_pkg, tlbfl_in_if, tlbfl_out_if and the unit's RTL.
module tb_tlb_fifo_lru_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tlbfl_pkg::*;

  localparam int ENTRIES        = DEF_ENTRIES;
  localparam int PB             = DEF_PAGE_BITS;
  localparam int FB             = DEF_FRAME_BITS;
  localparam op_t OP_UNUSED     = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASES         = 10;
  localparam int PHASE_WORDS    = 125;
  localparam int POOL_MAX       = 24;

  typedef logic [PB-1:0] page_t;
  typedef logic [FB-1:0] frame_t;

  // Expected outcome of one word.
  typedef struct {
    logic   hit;
    frame_t frame_out;
  } translation_t;

  // Shadow copy of the translation table; it predicts each word's outcome and
  // keeps the outcomes still due from the unit.
  class tlb_shadow;
    page_t        tag[ENTRIES];
    frame_t       frame_of[ENTRIES];
    bit [31:0]    stamp[ENTRIES];
    int           filled;
    int           oldest;
    bit [31:0]    use_count;
    bit [4:0]     cap_reg;
    bit           lru;
    translation_t due[$];
    int           errors;

    function new();
      filled    = 0;
      oldest    = 0;
      use_count = 0;
      cap_reg   = RESET_ENTRIES_IN_USE;
      lru       = POLICY_FIFO;
      errors    = 0;
    endfunction

    function int slot_at(int pos);
      return (oldest + pos) % ENTRIES;
    endfunction

    // Ring position count, never beyond the table size.
    function int live();
      return (filled > ENTRIES) ? ENTRIES : filled;
    endfunction

    function int find(page_t page);
      for (int i = 0; i < live(); i++) begin
        if (tag[slot_at(i)] == page) return slot_at(i);
      end
      return -1;
    endfunction

    function int capacity();
      int c;
      c = cap_reg;
      if (c < 1) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
    endfunction

    function void fill(int s, page_t page, frame_t frame);
      tag[s]      = page;
      frame_of[s] = frame;
      stamp[s]    = use_count;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_ENTRIES_IN_USE) cap_reg = data;
      else lru = data[0];
    endfunction

    function void insert(page_t page, frame_t frame);
      int s;
      int best;
      s = find(page);
      if (s >= 0) begin
        // A page already present is refreshed in place.
        fill(s, page, frame);
      end else if (filled < capacity()) begin
        fill(slot_at(filled), page, frame);
        filled++;
      end else if (lru == POLICY_FIFO) begin
        // Drop the front of the ring and append at its back.
        fill(slot_at(live()), page, frame);
        oldest = slot_at(1);
      end else begin
        // Smallest stamp wins; on a tie the later insertion is taken.
        best = slot_at(0);
        for (int i = 1; i < live(); i++) begin
          if (!(stamp[best] < stamp[slot_at(i)])) best = slot_at(i);
        end
        fill(best, page, frame);
      end
      use_count++;
    endfunction

    function void apply_word(op_t op, page_t page, frame_t frame);
      translation_t t;
      int s;
      t.hit       = 1'b0;
      t.frame_out = '0;
      case (op)
        OP_LOOKUP: begin
          s = find(page);
          if (s >= 0) begin
            t.hit       = 1'b1;
            t.frame_out = frame_of[s];
            stamp[s]    = use_count;
            use_count++;
          end
        end
        OP_INSERT: insert(page, frame);
        OP_FLUSH: begin
          filled    = 0;
          oldest    = 0;
          use_count = 0;
        end
        default: ;
      endcase
      due.push_back(t);
    endfunction

    function void match_translation(logic hit, frame_t frame_out);
      translation_t t;
      if (due.size() == 0) begin
        $error("unexpected result word: hit %0b frame_out 0x%05h", hit, frame_out);
        errors++;
        return;
      end
      t = due.pop_front();
      if (hit !== t.hit) begin
        $error("field hit: expected %0b, actual %0b", t.hit, hit);
        errors++;
      end
      if (frame_out !== t.frame_out) begin
        $error("field frame_out: expected 0x%05h, actual 0x%05h", t.frame_out, frame_out);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  tlbfl_in_if #(.PAGE_BITS(PB), .FRAME_BITS(FB)) in_ch ();
  tlbfl_out_if #(.FRAME_BITS(FB)) out_ch ();

  tlb_fifo_lru_unit #(
    .ENTRIES(ENTRIES),
    .PAGE_BITS(PB),
    .FRAME_BITS(FB)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  tlb_shadow shadow = new();

  bit    send_idle;
  bit    sink_idle;
  bit    hold_request;
  int    stall_cycles;
  page_t pool[POOL_MAX];
  int    pool_n;

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycles to wait before the next word on one side.
  function automatic int draw_gap(bit idle_on);
    if (!idle_on) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic page_t pick_page();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return pool[$urandom_range(0, pool_n - 1)];
    if (r < 90) return '0;
    if (r < 93) return '1;
    return page_t'($urandom);
  endfunction

  function automatic frame_t pick_frame();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return frame_t'($urandom);
  endfunction

  // Offer one word and hold it until accepted. Entered and left at a falling edge.
  task automatic send_word(op_t op, page_t page, frame_t frame);
    int gap;
    gap = draw_gap(send_idle);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.op    = op;
    in_ch.page  = page;
    in_ch.frame = frame;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    shadow.apply_word(op, page, frame);
    @(negedge clk);
  endtask

  // Wait until every outcome has come back, then let the unit settle.
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (shadow.due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow.set_reg(idx, data);
  endtask

  // Result side: random ready gaps, one long hold-off on request.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = draw_gap(sink_idle);
      if (hold_request) begin
        gap          = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      shadow.match_translation(out_ch.hit, out_ch.frame_out);
      @(negedge clk);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tlb_fifo_lru_unit: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int         r;
    int         caps[PHASES] = '{16, 1, 31, 0, 4, 2, 9, 17, 16, 3};
    op_t        op;
    logic [3:0] junk;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_LOOKUP;
    in_ch.page   = '0;
    in_ch.frame  = '0;
    send_idle    = 1'b1;
    sink_idle    = 1'b1;
    hold_request = 1'b0;
    stall_cycles = 0;
    pool_n       = 1;
    pool[0]      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: field extremes, every operation, refresh of a present page.
    write_reg(REG_ENTRIES_IN_USE, 5'd16);
    write_reg(REG_POLICY, {4'd0, POLICY_FIFO});
    send_word(OP_LOOKUP, '0, '1);
    send_word(OP_INSERT, '0, '1);
    send_word(OP_INSERT, '1, '0);
    send_word(OP_LOOKUP, '1, '1);
    send_word(OP_LOOKUP, '0, '0);
    send_word(OP_INSERT, '0, 20'h5a5a5);
    send_word(OP_LOOKUP, '0, '0);
    send_word(OP_UNUSED, '1, '1);
    send_word(OP_LOOKUP, '1, '0);
    send_word(OP_FLUSH, '1, '1);
    send_word(OP_LOOKUP, '1, '0);

    // FIFO eviction with room for two.
    wait_drained();
    write_reg(REG_ENTRIES_IN_USE, 5'd2);
    send_word(OP_INSERT, 20'h00011, 20'h0aaaa);
    send_word(OP_INSERT, 20'h00022, 20'h0bbbb);
    send_word(OP_INSERT, 20'h00033, 20'h0cccc);
    send_word(OP_LOOKUP, 20'h00011, '0);
    send_word(OP_LOOKUP, 20'h00022, '0);

    // LRU: the recently used entry survives.
    wait_drained();
    write_reg(REG_POLICY, {4'd0, POLICY_LRU});
    send_word(OP_INSERT, 20'h00044, 20'h0dddd);
    send_word(OP_LOOKUP, 20'h00033, '0);
    send_word(OP_LOOKUP, 20'h00022, '0);

    // A capacity of zero clamps to one and lies under the filled count.
    wait_drained();
    write_reg(REG_ENTRIES_IN_USE, 5'd0);
    send_word(OP_INSERT, 20'h00055, 20'h0eeee);
    send_word(OP_LOOKUP, 20'h00055, '0);

    // Capacity above the table size clamps to the table size.
    wait_drained();
    write_reg(REG_ENTRIES_IN_USE, 5'd31);
    send_word(OP_INSERT, 20'h00066, 20'h0ffff);

    // Random phases, each with its own capacity, policy, page pool and idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      junk = 4'($urandom);
      write_reg(REG_ENTRIES_IN_USE, 5'(caps[ph]));
      write_reg(REG_POLICY, {junk, ((ph % 2) != 0) ^ (ph >= 8)});
      r         = (ph == 0) ? 3 : $urandom_range(0, 3);
      send_idle = r[0];
      sink_idle = r[1];
      if (ph == 2 || ph == 6) hold_request = 1'b1;
      pool_n = $urandom_range(2, POOL_MAX);
      for (int i = 0; i < pool_n; i++) pool[i] = page_t'($urandom);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 52) op = OP_LOOKUP;
        else if (r < 94) op = OP_INSERT;
        else if (r < 97) op = OP_UNUSED;
        else op = OP_FLUSH;
        send_word(op, pick_page(), pick_frame());
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (shadow.errors == 0 && shadow.due.size() == 0) begin
      $display("tlb_fifo_lru_unit: match");
    end else begin
      $display("tlb_fifo_lru_unit: mismatch");
    end
    $finish;
  end

endmodule
